FILE: design/bounded_array_list_engine_macros.svh
// Assertion macros for the bounded array list engine.
// Header only; no dependencies. Used by the datapath module.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held (active low).
`define BALE_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held (active low).
`define BALE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bale_pkg.sv
// Shared codes and controller/datapath interface types for the array list engine.
// No dependencies.
package bale_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DELETE     = 3'd4;
  localparam logic [2:0] OP_SEARCH     = 3'd5;
  localparam logic [2:0] OP_REVERSE    = 3'd6;
  localparam logic [2:0] OP_DUMP       = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef logic [2:0] act_t;

  localparam act_t ACT_NONE       = 3'd0;
  localparam act_t ACT_PUSH_FRONT = 3'd1;
  localparam act_t ACT_PUSH_BACK  = 3'd2;
  localparam act_t ACT_DELETE     = 3'd3;
  localparam act_t ACT_POP_BACK   = 3'd4;
  localparam act_t ACT_ROTATE     = 3'd5;

  typedef struct packed {
    act_t       act;
    logic       capture;
    logic       accum;
    logic       load_out;
    logic [1:0] status;
    logic       last;
    logic       use_data;
    logic       use_found;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic full;
    logic single;
  } sts_t;

endpackage

FILE: design/bale_ctrl.sv
// Controller FSM: decodes requests and sequences search, reverse and dump.
// Depends on bale_pkg; drives bale_datapath through cmd_t and a cell position.
module bale_ctrl #(
  parameter int CAPACITY = 16,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_operation,
  input  logic [3:0]      in_index,
  input  bale_pkg::sts_t  sts,
  input  logic [CW-1:0]   count,
  output bale_pkg::cmd_t  cmd,
  output logic [IW-1:0]   pos
);
  import bale_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SEARCH  = 2'd1;
  localparam logic [1:0] S_REVERSE = 2'd2;
  localparam logic [1:0] S_DUMP    = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] step_r, step_nxt;
  logic [CW-1:0] cm1, cm2;
  logic [CW+3:0] idx_w, cnt_w;
  logic [IW+3:0] idx_ext;
  logic          idx_bad;
  logic          final_step;

  assign cm1     = count - CW'(1);
  assign cm2     = count - CW'(2);
  assign idx_w   = {{CW{1'b0}}, in_index};
  assign cnt_w   = {4'b0000, count};
  assign idx_bad = (idx_w >= cnt_w);
  assign idx_ext = {{IW{1'b0}}, in_index};

  always_comb begin
    cmd        = '0;
    cmd.act    = ACT_NONE;
    cmd.status = ST_OK;
    pos        = '0;
    in_ready   = 1'b0;
    state_nxt  = state_r;
    step_nxt   = step_r;
    final_step = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.capture  = 1'b1;
          cmd.load_out = 1'b1;
          cmd.last     = 1'b1;
          step_nxt     = '0;
          unique case (in_operation)
            OP_PUSH_FRONT: begin
              if (sts.full) cmd.status = ST_FULL;
              else cmd.act = ACT_PUSH_FRONT;
            end
            OP_PUSH_BACK: begin
              if (sts.full) cmd.status = ST_FULL;
              else cmd.act = ACT_PUSH_BACK;
            end
            OP_POP_FRONT: begin
              if (sts.empty) cmd.status = ST_EMPTY;
              else cmd.act = ACT_DELETE;
            end
            OP_POP_BACK: begin
              if (sts.empty) cmd.status = ST_EMPTY;
              else cmd.act = ACT_POP_BACK;
            end
            OP_DELETE: begin
              pos = idx_ext[IW-1:0];
              if (sts.empty) cmd.status = ST_EMPTY;
              else if (idx_bad) cmd.status = ST_RANGE;
              else cmd.act = ACT_DELETE;
            end
            OP_SEARCH: begin
              if (!sts.empty) begin
                cmd.load_out = 1'b0;
                state_nxt    = S_SEARCH;
              end
            end
            OP_REVERSE: begin
              if (!sts.single) begin
                cmd.load_out = 1'b0;
                state_nxt    = S_REVERSE;
              end
            end
            OP_DUMP: begin
              if (sts.empty) cmd.status = ST_EMPTY;
              else begin
                cmd.load_out = 1'b0;
                state_nxt    = S_DUMP;
              end
            end
          endcase
        end
      end
      S_SEARCH: begin
        pos        = cm1[IW-1:0];
        final_step = (step_r == cm1[IW-1:0]);
        if (!final_step || sts.out_free) begin
          cmd.act   = ACT_ROTATE;
          cmd.accum = 1'b1;
          if (final_step) begin
            cmd.load_out  = 1'b1;
            cmd.use_found = 1'b1;
            cmd.last      = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      S_REVERSE: begin
        // move the front entry to slot k, k walking down from count-1 to 1
        pos        = cm1[IW-1:0] - step_r;
        final_step = (step_r == cm2[IW-1:0]);
        if (!final_step || sts.out_free) begin
          cmd.act = ACT_ROTATE;
          if (final_step) begin
            cmd.load_out = 1'b1;
            cmd.last     = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      S_DUMP: begin
        pos        = cm1[IW-1:0];
        final_step = (step_r == cm1[IW-1:0]);
        if (sts.out_free) begin
          cmd.act      = ACT_ROTATE;
          cmd.load_out = 1'b1;
          cmd.use_data = 1'b1;
          cmd.last     = final_step;
          if (final_step) state_nxt = S_IDLE;
          else step_nxt = step_r + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

FILE: design/bale_datapath.sv
// Datapath: row of list cells, live count, search accumulator and output register.
// Depends on bale_pkg and bounded_array_list_engine_macros.svh; driven by bale_ctrl.
`include "bounded_array_list_engine_macros.svh"

module bale_datapath #(
  parameter int CAPACITY = 16,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bale_pkg::cmd_t     cmd,
  input  logic [IW-1:0]      pos,
  input  logic signed [31:0] in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic signed [31:0] out_data,
  output logic               out_last,
  output logic [4:0]         out_occupancy,
  output bale_pkg::sts_t     sts,
  output logic [CW-1:0]      count
);
  import bale_pkg::*;

  logic signed [31:0] cells_r [CAPACITY];
  logic signed [31:0] val_r;
  logic               found_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW+4:0]      occ_ext;
  logic               match;
  logic               out_free_w;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic               out_found_r;
  logic signed [31:0] out_data_r;
  logic               out_last_r;
  logic [4:0]         out_occ_r;

  assign match = (cells_r[0] == val_r);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;
    logic signed [31:0] cell_nxt;

    always_comb begin
      cell_nxt = cells_r[g];
      case (cmd.act)
        ACT_PUSH_FRONT: begin
          if (g == 0) cell_nxt = in_value;
          else cell_nxt = cells_r[PREV];
        end
        ACT_PUSH_BACK: begin
          if (count_r == CW'(g)) cell_nxt = in_value;
        end
        ACT_DELETE: begin
          if (IW'(g) >= pos) cell_nxt = cells_r[NEXT];
        end
        ACT_ROTATE: begin
          if (IW'(g) < pos) cell_nxt = cells_r[NEXT];
          else if (IW'(g) == pos) cell_nxt = cells_r[0];
        end
        default: cell_nxt = cells_r[g];
      endcase
    end

    always_ff @(posedge clk) begin
      cells_r[g] <= cell_nxt;
    end
  end

  always_comb begin
    case (cmd.act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: count_nxt = count_r + CW'(1);
      ACT_DELETE, ACT_POP_BACK:      count_nxt = count_r - CW'(1);
      default:                       count_nxt = count_r;
    endcase
  end

  assign occ_ext    = {5'b00000, count_nxt};
  assign out_free_w = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r   <= in_value;
      found_r <= 1'b0;
    end else if (cmd.accum) begin
      found_r <= found_r | match;
    end
    if (cmd.load_out) begin
      out_status_r <= cmd.status;
      out_found_r  <= cmd.use_found & (found_r | match);
      out_data_r   <= cmd.use_data ? cells_r[0] : 32'sd0;
      out_last_r   <= cmd.last;
      out_occ_r    <= occ_ext[4:0];
    end
  end

  assign sts.out_free = out_free_w;
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CW'(CAPACITY));
  assign sts.single   = (count_r < CW'(2));
  assign count        = count_r;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_data      = out_data_r;
  assign out_last      = out_last_r;
  assign out_occupancy = out_occ_r;

  `BALE_ASSERT_IMPLY(a_load_free, clk, rst_n, cmd.load_out, out_free_w,
                     "result beat overwritten before it was taken")
  `BALE_ASSERT_IMPLY(a_push_room, clk, rst_n,
                     cmd.act == ACT_PUSH_FRONT || cmd.act == ACT_PUSH_BACK,
                     count_r != CW'(CAPACITY), "insert into a full list")
  `BALE_ASSERT_IMPLY(a_remove_live, clk, rst_n,
                     cmd.act == ACT_DELETE || cmd.act == ACT_POP_BACK,
                     count_r != '0 && pos < count_r, "removal outside live entries")
  `BALE_ASSERT_IMPLY(a_rotate_range, clk, rst_n, cmd.act == ACT_ROTATE,
                     pos < count_r, "rotation reaches a dead slot")

endmodule

FILE: design/bounded_array_list_engine.sv
// Bounded array list engine: ordered list of up to CAPACITY signed 32-bit values.
// Input channel (in_*) takes one request per beat: push front/back, pop front/back,
// delete at index, search, reverse or dump. Result channel (out_*) returns status,
// found, data, last and occupancy; every request gives one beat with last set,
// except dump of a non-empty list, which gives one beat per live entry, front first.
// Push, pop, delete and the rejected cases finish at the accepting edge, which also
// loads the result into the output register. Search and reverse step through the live
// entries by single-step rotation of the cell row; dump gives one beat per cycle
// while out_ready stays high.
// A new request is taken once the sequencer is idle and the output register is
// empty or being drained, so back-to-back single-beat requests run at one per cycle.
// When out_ready is low with a beat pending, no request is taken; search and reverse
// run on to their last step and wait there, and dump waits on its current entry.
// Reset (rst_n low, synchronous) empties the list and drops any pending beat.
// Depends on bale_pkg, bale_ctrl and bale_datapath.
module bounded_array_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_value,
  input  logic [3:0]         in_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic signed [31:0] out_data,
  output logic               out_last,
  output logic [4:0]         out_occupancy
);
  import bale_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] pos;
  logic [CW-1:0] count;

  bale_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_index     (in_index),
    .sts          (sts),
    .count        (count),
    .cmd          (cmd),
    .pos          (pos)
  );

  bale_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .pos           (pos),
    .in_value      (in_value),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_found     (out_found),
    .out_data      (out_data),
    .out_last      (out_last),
    .out_occupancy (out_occupancy),
    .sts           (sts),
    .count         (count)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_array_list_engine: a directed table, then random requests,
// each checked beat by beat against a shadow copy of the list. Depends on bale_pkg and the engine.
module testbench;
  import bale_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 386;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] data;
    logic               last;
    logic [4:0]         occupancy;
  } beat_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] val;
    logic [3:0]  idx;
    int          reps;
    bit          typed;
    logic [1:0]  st;
    logic        fnd;
    logic [4:0]  occ;
  } step_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_operation;
  logic signed [31:0] in_value;
  logic [3:0]         in_index;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic               out_found;
  logic signed [31:0] out_data;
  logic               out_last;
  logic [4:0]         out_occupancy;

  beat_t              awaited_beats [$];
  logic signed [31:0] shadow_list [DEPTH];
  int                 shadow_count = 0;
  int                 fail_count = 0;
  int                 quiet_cycles = 0;
  bit                 calm = 1'b0;
  int                 hold_asks = 0;

  bounded_array_list_engine #(.CAPACITY(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_data     (out_data),
    .out_last     (out_last),
    .out_occupancy(out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic step_t row(logic [2:0] op, logic [31:0] val, logic [3:0] idx, int reps,
                                bit typed, logic [1:0] st, logic fnd, logic [4:0] occ);
    row = '{op, val, idx, reps, typed, st, fnd, occ};
  endfunction

  task automatic queue_beat(logic [1:0] st, logic fnd, logic signed [31:0] dat, logic lst);
    awaited_beats.push_back('{st, fnd, dat, lst, shadow_count[4:0]});
  endtask

  // Shadow list update; queues the beats the engine owes for this request.
  task automatic apply_list_op(logic [2:0] op, logic signed [31:0] val, logic [3:0] idx);
    int                 i;
    logic signed [31:0] t;
    logic [1:0]         st;
    logic               fnd;
    st  = ST_OK;
    fnd = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) st = ST_FULL;
        else begin
          for (i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = val;
          shadow_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) st = ST_FULL;
        else begin
          shadow_list[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else begin
          for (i = 0; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else shadow_count--;
      end
      OP_DELETE: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else if (int'(idx) >= shadow_count) st = ST_RANGE;
        else begin
          for (i = int'(idx); i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < shadow_count; i++)
          if (shadow_list[i] == val) fnd = 1'b1;
      end
      OP_REVERSE: begin
        for (i = 0; i < shadow_count / 2; i++) begin
          t = shadow_list[i];
          shadow_list[i] = shadow_list[shadow_count-1-i];
          shadow_list[shadow_count-1-i] = t;
        end
      end
      default: begin
        if (shadow_count == 0) queue_beat(ST_EMPTY, 1'b0, 32'sd0, 1'b1);
        else
          for (i = 0; i < shadow_count; i++)
            queue_beat(ST_OK, 1'b0, shadow_list[i], i == shadow_count - 1);
        return;
      end
    endcase
    queue_beat(st, fnd, 32'sd0, 1'b1);
  endtask

  // Entered and left at a falling edge; valid stays high when the next beat follows at once.
  task automatic send_request(logic [2:0] op, logic signed [31:0] val, logic [3:0] idx,
                              bit typed, beat_t want);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    in_index     <= idx;
    do @(posedge clk); while (!in_ready);
    apply_list_op(op, val, idx);
    if (typed) begin
      void'(awaited_beats.pop_back());
      awaited_beats.push_back(want);
    end
    @(negedge clk);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got status %0d data %h", $time,
                 out_status, out_data);
        fail_count++;
      end else begin
        want = awaited_beats.pop_front();
        compare_field("status", want.status, out_status);
        compare_field("found", want.found, out_found);
        compare_field("data", want.data, out_data);
        compare_field("last", want.last, out_last);
        compare_field("occupancy", want.occupancy, out_occupancy);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side back-pressure, plus the long hold-off on request.
  initial begin
    int n;
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_asks != holds_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        n = gap_len();
        if (n == 0) begin
          out_ready <= 1'b1;
          @(negedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
      end
    end
  end

  initial begin
    step_t              plan [$];
    beat_t              want;
    int                 k;
    int                 n;
    int                 r;
    int                 grow;
    logic [2:0]         op;
    logic signed [31:0] val;
    logic [3:0]         idx;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_PUSH_FRONT;
    in_value     = '0;
    in_index     = '0;
    grow         = 50;

    plan.push_back(row(OP_POP_FRONT,  32'h0,        4'd0,  1,  1, ST_EMPTY, 1'b0, 5'd0));
    plan.push_back(row(OP_POP_BACK,   32'h0,        4'd0,  1,  1, ST_EMPTY, 1'b0, 5'd0));
    plan.push_back(row(OP_DELETE,     32'h0,        4'd0,  1,  1, ST_EMPTY, 1'b0, 5'd0));
    plan.push_back(row(OP_SEARCH,     32'h0,        4'd0,  1,  1, ST_OK,    1'b0, 5'd0));
    plan.push_back(row(OP_REVERSE,    32'h0,        4'd0,  1,  1, ST_OK,    1'b0, 5'd0));
    plan.push_back(row(OP_DUMP,       32'h0,        4'd0,  1,  1, ST_EMPTY, 1'b0, 5'd0));
    plan.push_back(row(OP_PUSH_BACK,  32'h7fffffff, 4'd0,  1,  1, ST_OK,    1'b0, 5'd1));
    plan.push_back(row(OP_REVERSE,    32'h0,        4'd0,  1,  1, ST_OK,    1'b0, 5'd1));
    plan.push_back(row(OP_PUSH_FRONT, 32'h80000000, 4'd0,  1,  1, ST_OK,    1'b0, 5'd2));
    plan.push_back(row(OP_SEARCH,     32'h80000000, 4'd0,  1,  1, ST_OK,    1'b1, 5'd2));
    plan.push_back(row(OP_DELETE,     32'h0,        4'd15, 1,  1, ST_RANGE, 1'b0, 5'd2));
    plan.push_back(row(OP_DELETE,     32'h0,        4'd2,  1,  1, ST_RANGE, 1'b0, 5'd2));
    plan.push_back(row(OP_PUSH_BACK,  32'hffffffff, 4'd0,  14, 0, ST_OK,    1'b0, 5'd0));
    plan.push_back(row(OP_PUSH_FRONT, 32'h0,        4'd0,  1,  1, ST_FULL,  1'b0, 5'd16));
    plan.push_back(row(OP_PUSH_BACK,  32'h0,        4'd0,  1,  1, ST_FULL,  1'b0, 5'd16));
    plan.push_back(row(OP_SEARCH,     32'h0,        4'd0,  1,  1, ST_OK,    1'b0, 5'd16));
    plan.push_back(row(OP_REVERSE,    32'h0,        4'd0,  1,  0, ST_OK,    1'b0, 5'd0));
    plan.push_back(row(OP_DUMP,       32'h0,        4'd0,  1,  0, ST_OK,    1'b0, 5'd0));
    plan.push_back(row(OP_DELETE,     32'h0,        4'd15, 1,  0, ST_OK,    1'b0, 5'd0));
    plan.push_back(row(OP_POP_FRONT,  32'h0,        4'd0,  1,  0, ST_OK,    1'b0, 5'd0));
    plan.push_back(row(OP_POP_BACK,   32'h0,        4'd0,  1,  0, ST_OK,    1'b0, 5'd0));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < plan.size(); k++)
      repeat (plan[k].reps) begin
        want = '{plan[k].st, plan[k].fnd, 32'sd0, 1'b1, plan[k].occ};
        send_request(plan[k].op, plan[k].val, plan[k].idx, plan[k].typed, want);
      end

    // Phases lean towards growing or shrinking so the list swings between empty and full.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        r    = $urandom_range(0, 2);
        grow = (r == 0) ? 20 : (r == 1) ? 50 : 85;
        calm = ($urandom_range(0, 3) == 0);
      end
      if (n == 120 || n == 300) begin
        calm = 1'b1;
        hold_asks++;
      end
      r = $urandom_range(0, 99);
      if (r < 10) op = OP_DUMP;
      else if (r < 22) op = OP_SEARCH;
      else if (r < 28) op = OP_REVERSE;
      else if ($urandom_range(0, 99) < grow)
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else begin
        r  = $urandom_range(0, 4);
        op = (r == 0) ? OP_POP_FRONT : (r == 1) ? OP_POP_BACK : OP_DELETE;
      end
      r = $urandom_range(0, 9);
      if (r < 3) val = $urandom_range(0, 7) - 4;
      else if (r < 6 && shadow_count > 0) val = shadow_list[$urandom_range(0, shadow_count - 1)];
      else val = $urandom;
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
        idx = $urandom_range(0, shadow_count - 1);
      else idx = $urandom_range(0, 15);
      send_request(op, val, idx, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
